FILE: hdl/mrn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrn_pkg
// Shared types and constants for the max-reachable-node graph walker.
// ----------------------------------------------------------------------------
package mrn_pkg;

  localparam int NODE_W = 8;  // node id field width
  localparam int KIND_W = 2;  // request kind field width
  localparam int CFG_W  = 9;  // node_count register width

  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

endpackage

FILE: hdl/mrn_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrn_req_if
// Request channel: edge, query or clear request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrn_req_if import mrn_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [NODE_W-1:0] src_node;
  logic [NODE_W-1:0] dst_node;

  modport source (output valid, kind, src_node, dst_node, input ready);
  modport sink   (input valid, kind, src_node, dst_node, output ready);
endinterface

FILE: hdl/mrn_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrn_rsp_if
// Response channel: query result with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrn_rsp_if import mrn_pkg::*;;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] max_node;
  logic              edges_dropped;
  logic              bad_node;

  modport source (output valid, max_node, edges_dropped, bad_node, input ready);
  modport sink   (input valid, max_node, edges_dropped, bad_node, output ready);
endinterface

FILE: hdl/mrn_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrn_cfg
// node_count register, saturated to 1..MAX_NODES on write.
// ----------------------------------------------------------------------------
module mrn_cfg import mrn_pkg::*; #(
  parameter int MAX_NODES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [CFG_W-1:0] wdata_i,
  output logic [CFG_W-1:0] node_count_o
);

  localparam int NodeRst = (MAX_NODES < 256) ? MAX_NODES : 256;

  logic [CFG_W-1:0] node_count_q, node_count_d;

  always_comb begin
    if (wdata_i == '0) begin
      node_count_d = CFG_W'(1);
    end else if (int'(wdata_i) > MAX_NODES) begin
      node_count_d = CFG_W'(MAX_NODES);
    end else begin
      node_count_d = wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CFG_W'(NodeRst);
    end else if (we_i) begin
      node_count_q <= node_count_d;
    end
  end

  assign node_count_o = node_count_q;

endmodule

FILE: hdl/max_reachable_node_dfs_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_reachable_node_dfs_top
// Directed graph in per-node arc lists; depth-first walk returns the largest
// node id reachable from a start node.
// ----------------------------------------------------------------------------
// Edge request: stores the arc, or returns straight to idle when ignored or
// dropped. Clear: sweeps the arc-list heads. Query: accept, sweep the visited
// map, load the root, examine each arc, pop each frame, then load the output
// register; a bad start skips the walk and goes straight to the output register.
// One request at a time. After reset the arc-list heads are swept before the
// first request is taken.
module max_reachable_node_dfs_top import mrn_pkg::*; #(
  parameter int MAX_NODES = 256,
  parameter int MAX_EDGES = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  mrn_req_if.sink          req_i,
  mrn_rsp_if.source        rsp_o
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int PW = $clog2(MAX_EDGES + 1);
  localparam int DW = $clog2(MAX_NODES + 1);

  localparam logic [3:0] S_GCLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_EDGE = 4'd2;
  localparam logic [3:0] S_VCLR = 4'd3;
  localparam logic [3:0] S_HEAD = 4'd4;
  localparam logic [3:0] S_ROOT = 4'd5;
  localparam logic [3:0] S_ARC  = 4'd6;
  localparam logic [3:0] S_TGT  = 4'd7;
  localparam logic [3:0] S_SEEN = 4'd8;
  localparam logic [3:0] S_POP  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [CFG_W-1:0] node_count;

  mrn_cfg #(.MAX_NODES(MAX_NODES)) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .we_i         (cfg_we_i),
    .wdata_i      (cfg_wdata_i),
    .node_count_o (node_count)
  );

  // control state
  logic [3:0]        state_q, state_d;
  logic [NW-1:0]     sweep_q, sweep_d;
  logic [PW-1:0]     arc_cnt_q, arc_cnt_d;
  logic              ovf_q, ovf_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic              rsp_vld_q;
  // payload
  logic [NODE_W-1:0] src_q, dst_q;
  logic [PW-1:0]     top_arc_q, top_arc_d;
  logic [NODE_W-1:0] best_q, best_d;
  logic              bad_q, bad_d;
  logic [NODE_W-1:0] rsp_max_q;
  logic              rsp_drop_q, rsp_bad_q;

  // memories
  logic [PW-1:0]     head_mem [MAX_NODES];
  logic [PW-1:0]     next_mem [MAX_EDGES];
  logic [NODE_W-1:0] tgt_mem  [MAX_EDGES];
  logic              seen_mem [MAX_NODES];
  logic [PW-1:0]     stk_mem  [MAX_NODES];

  logic              head_re, head_we;
  logic [NW-1:0]     head_ra, head_wa;
  logic [PW-1:0]     head_wd, head_rd_q;
  logic              arc_re, arc_we;
  logic [PW-1:0]     next_rd_q;
  logic [NODE_W-1:0] tgt_rd_q;
  logic              seen_re, seen_we, seen_wd, seen_rd_q;
  logic [NW-1:0]     seen_wa;
  logic              stk_re, stk_we;
  logic [PW-1:0]     stk_rd_q;

  logic req_acc, src_ok, dst_ok, sweep_last, rsp_load;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign src_ok      = {1'b0, req_i.src_node} < node_count;
  assign dst_ok      = {1'b0, req_i.dst_node} < node_count;
  assign sweep_last  = (sweep_q == NW'(MAX_NODES - 1));
  assign rsp_load    = (state_q == S_OUT) && (!rsp_vld_q || rsp_o.ready);

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    arc_cnt_d = arc_cnt_q;
    ovf_d     = ovf_q;
    depth_d   = depth_q;
    top_arc_d = top_arc_q;
    best_d    = best_q;
    bad_d     = bad_q;
    head_re   = 1'b0;
    head_ra   = NW'(req_i.src_node);
    head_we   = 1'b0;
    head_wa   = sweep_q;
    head_wd   = PW'(MAX_EDGES);
    arc_re    = 1'b0;
    arc_we    = 1'b0;
    seen_re   = 1'b0;
    seen_we   = 1'b0;
    seen_wa   = sweep_q;
    seen_wd   = 1'b0;
    stk_re    = 1'b0;
    stk_we    = 1'b0;

    case (state_q)
      S_GCLR: begin
        head_we = 1'b1;
        sweep_d = sweep_q + NW'(1);
        if (sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          head_re = 1'b1;
          case (kind_e'(req_i.kind))
            KIND_EDGE: begin
              if (src_ok && dst_ok) begin
                if (arc_cnt_q == PW'(MAX_EDGES)) begin
                  ovf_d = 1'b1;
                end else begin
                  state_d = S_EDGE;
                end
              end
            end
            KIND_QUERY: begin
              if (src_ok) begin
                sweep_d = '0;
                state_d = S_VCLR;
              end else begin
                best_d  = '0;
                bad_d   = 1'b1;
                state_d = S_OUT;
              end
            end
            KIND_CLEAR: begin
              sweep_d   = '0;
              arc_cnt_d = '0;
              ovf_d     = 1'b0;
              state_d   = S_GCLR;
            end
            default: ;
          endcase
        end
      end
      S_EDGE: begin
        // push the new arc at the head of the source list
        arc_we    = 1'b1;
        head_we   = 1'b1;
        head_wa   = NW'(src_q);
        head_wd   = arc_cnt_q;
        arc_cnt_d = arc_cnt_q + PW'(1);
        state_d   = S_IDLE;
      end
      S_VCLR: begin
        seen_we = 1'b1;
        sweep_d = sweep_q + NW'(1);
        if (sweep_last) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        head_re = 1'b1;
        head_ra = NW'(src_q);
        seen_we = 1'b1;
        seen_wa = NW'(src_q);
        seen_wd = 1'b1;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        top_arc_d = head_rd_q;
        depth_d   = DW'(1);
        best_d    = src_q;
        bad_d     = 1'b0;
        state_d   = S_ARC;
      end
      S_ARC: begin
        if (top_arc_q < arc_cnt_q) begin
          arc_re  = 1'b1;
          state_d = S_TGT;
        end else begin
          // list exhausted: drop the frame
          depth_d = depth_q - DW'(1);
          if (depth_q == DW'(1)) begin
            state_d = S_OUT;
          end else begin
            stk_re  = 1'b1;
            state_d = S_POP;
          end
        end
      end
      S_POP: begin
        top_arc_d = stk_rd_q;
        state_d   = S_ARC;
      end
      S_TGT: begin
        top_arc_d = next_rd_q;
        seen_re   = 1'b1;
        head_re   = 1'b1;
        head_ra   = NW'(tgt_rd_q);
        state_d   = S_SEEN;
      end
      S_SEEN: begin
        state_d = S_ARC;
        if (!seen_rd_q) begin
          seen_we = 1'b1;
          seen_wa = NW'(tgt_rd_q);
          seen_wd = 1'b1;
          if (tgt_rd_q > best_q) begin
            best_d = tgt_rd_q;
          end
          if (depth_q < DW'(MAX_NODES)) begin
            stk_we    = 1'b1;
            top_arc_d = head_rd_q;
            depth_d   = depth_q + DW'(1);
          end
        end
      end
      S_OUT: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_GCLR;
      sweep_q   <= '0;
      arc_cnt_q <= '0;
      ovf_q     <= 1'b0;
      depth_q   <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      arc_cnt_q <= arc_cnt_d;
      ovf_q     <= ovf_d;
      depth_q   <= depth_d;
      if (rsp_load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      src_q <= req_i.src_node;
      dst_q <= req_i.dst_node;
    end
    top_arc_q <= top_arc_d;
    best_q    <= best_d;
    bad_q     <= bad_d;
    if (rsp_load) begin
      rsp_max_q  <= best_q;
      rsp_drop_q <= ovf_q;
      rsp_bad_q  <= bad_q;
    end
  end

  // list heads
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (head_re) begin
      head_rd_q <= head_mem[head_ra];
    end
  end

  // arc store
  always_ff @(posedge clk_i) begin
    if (arc_we) begin
      next_mem[AW'(arc_cnt_q)] <= head_rd_q;
      tgt_mem[AW'(arc_cnt_q)]  <= dst_q;
    end
    if (arc_re) begin
      next_rd_q <= next_mem[AW'(top_arc_q)];
      tgt_rd_q  <= tgt_mem[AW'(top_arc_q)];
    end
  end

  // visited map
  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    if (seen_re) begin
      seen_rd_q <= seen_mem[NW'(tgt_rd_q)];
    end
  end

  // walk stack: holds the frames below the top, whose arc stays in top_arc_q
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[NW'(depth_q - DW'(1))] <= top_arc_q;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[NW'(depth_q - DW'(2))];
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.max_node      = rsp_max_q;
  assign rsp_o.edges_dropped = rsp_drop_q;
  assign rsp_o.bad_node      = rsp_bad_q;

  a_arc_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arc_cnt_q <= PW'(MAX_EDGES))
    else $error("arc count beyond edge store");

  a_walk_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ARC || state_q == S_TGT || state_q == S_SEEN) |-> depth_q != '0)
    else $error("walk running with empty stack");

  a_best_covers_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_load && !bad_q) |-> best_q >= src_q)
    else $error("result below start node");

  a_clear_drops_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.kind == KIND_CLEAR) |=> !ovf_q && arc_cnt_q == '0)
    else $error("clear left graph state behind");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the max-reachable-node graph walker. Requests are
// queued by the stimulus block and driven at the falling edge. Accepted
// edge and clear requests update a local copy of the arc lists. Each query adds
// the expected answer, which is checked in order against the response channel.
// Runs directed cases, random phases under several idle and stall mixes, and a
// small-graph pass that ends with a clear and a query of the empty graph.
// ----------------------------------------------------------------------------
module tb_top;
  import mrn_pkg::*;

  localparam int MAX_NODES     = 256;
  localparam int MAX_EDGES     = 1024;
  localparam int ARC_W         = 11;
  localparam int SETTLE_CYCLES = 400;  // longer than a clear request
  localparam int MAX_REPORTS   = 10;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [ARC_W-1:0]  ARC_EMPTY   = ARC_W'(MAX_EDGES);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
  } graph_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] max_node;
    logic              edges_dropped;
    logic              bad_node;
  } answer_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  mrn_req_if req_if ();
  mrn_rsp_if rsp_if ();

  max_reachable_node_dfs_top #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Graph mirror
  logic [ARC_W-1:0]  arc_head [MAX_NODES];
  logic [ARC_W-1:0]  arc_link [MAX_EDGES];
  logic [NODE_W-1:0] arc_dst  [MAX_EDGES];
  logic              walk_seen [MAX_NODES];
  logic [ARC_W-1:0]  walk_arc  [MAX_NODES];
  int unsigned       arc_total;
  logic              store_overflow;
  int unsigned       nodes_in_use;

  graph_req_t  pending_req_q [$];
  answer_t     answer_q [$];
  logic        req_taken;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          mismatch_cnt;
  longint      cycle_cnt;
  longint      items_sent;

  function automatic void clear_graph();
    for (int i = 0; i < MAX_NODES; i++) arc_head[i] = ARC_EMPTY;
    arc_total      = 0;
    store_overflow = 1'b0;
  endfunction

  function automatic logic [NODE_W-1:0] walk_max_node(input logic [NODE_W-1:0] start);
    int                depth;
    logic [NODE_W-1:0] best;
    logic [NODE_W-1:0] nxt;
    logic [ARC_W-1:0]  arc;
    for (int i = 0; i < MAX_NODES; i++) walk_seen[i] = 1'b0;
    walk_seen[start] = 1'b1;
    walk_arc[0]      = arc_head[start];
    depth            = 1;
    best             = start;
    while (depth > 0) begin
      arc = walk_arc[depth-1];
      if (arc >= MAX_EDGES || arc >= arc_total) begin
        depth--;
      end else begin
        // advance the frame before descending
        walk_arc[depth-1] = arc_link[arc];
        nxt = arc_dst[arc];
        if (!walk_seen[nxt]) begin
          walk_seen[nxt] = 1'b1;
          if (nxt > best) best = nxt;
          if (depth < MAX_NODES) begin
            walk_arc[depth] = arc_head[nxt];
            depth++;
          end
        end
      end
    end
    return best;
  endfunction

  function automatic void apply_graph_request(input graph_req_t r);
    answer_t ans;
    if (r.kind == KIND_EDGE) begin
      if (r.src < nodes_in_use && r.dst < nodes_in_use) begin
        if (arc_total >= MAX_EDGES) begin
          store_overflow = 1'b1;
        end else begin
          arc_dst[arc_total]  = r.dst;
          arc_link[arc_total] = arc_head[r.src];
          arc_head[r.src]     = ARC_W'(arc_total);
          arc_total++;
        end
      end
    end else if (r.kind == KIND_QUERY) begin
      ans.edges_dropped = store_overflow;
      if (r.src >= nodes_in_use) begin
        ans.max_node = '0;
        ans.bad_node = 1'b1;
      end else begin
        ans.max_node = walk_max_node(r.src);
        ans.bad_node = 1'b0;
      end
      answer_q.push_back(ans);
    end else if (r.kind == KIND_CLEAR) begin
      clear_graph();
    end
  endfunction

  function automatic void note_mismatch(input string what, input answer_t exp_a,
                                        input answer_t got_a);
    if (mismatch_cnt < MAX_REPORTS)
      $display("[%0t] %s: exp max=%0d drop=%0b bad=%0b got max=%0d drop=%0b bad=%0b",
               $time, what, exp_a.max_node, exp_a.edges_dropped, exp_a.bad_node,
               got_a.max_node, got_a.edges_dropped, got_a.bad_node);
    mismatch_cnt++;
  endfunction

  // Request driver and response back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (!req_if.valid || req_taken) begin
        req_taken = 1'b0;
        if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid    <= 1'b1;
          req_if.kind     <= pending_req_q[0].kind;
          req_if.src_node <= pending_req_q[0].src;
          req_if.dst_node <= pending_req_q[0].dst;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Request and response monitor
  always @(posedge clk_i) begin
    answer_t got_a;
    answer_t exp_a;
    cycle_cnt++;
    if (rst_ni && req_if.valid && req_if.ready) begin
      apply_graph_request(pending_req_q.pop_front());
      req_taken = 1'b1;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got_a.max_node      = rsp_if.max_node;
      got_a.edges_dropped = rsp_if.edges_dropped;
      got_a.bad_node      = rsp_if.bad_node;
      if (answer_q.size() == 0) begin
        note_mismatch("unexpected response", '0, got_a);
      end else begin
        exp_a = answer_q.pop_front();
        if (got_a.max_node !== exp_a.max_node ||
            got_a.edges_dropped !== exp_a.edges_dropped ||
            got_a.bad_node !== exp_a.bad_node)
          note_mismatch("response mismatch", exp_a, got_a);
      end
    end
  end

  task automatic queue_request(input logic [KIND_W-1:0] kind, input int src, input int dst);
    graph_req_t r;
    r.kind = kind;
    r.src  = NODE_W'(src);
    r.dst  = NODE_W'(dst);
    pending_req_q.push_back(r);
    items_sent++;
  endtask

  task automatic wait_quiet();
    while (pending_req_q.size() != 0 || answer_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_node_count(input int value);
    int v;
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    // saturate into 1..MAX_NODES
    v = value & ((1 << CFG_W) - 1);
    if (v < 1) v = 1;
    if (v > MAX_NODES) v = MAX_NODES;
    nodes_in_use = v;
  endtask

  task automatic run_random(input int count, input int send_pct, input int stall_pct,
                            input int nodes);
    int pick;
    int s;
    set_node_count(nodes);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      s    = $urandom_range(nodes_in_use - 1);
      if (pick < 45)
        // chain links half the time so walks go deep
        queue_request(KIND_EDGE, s, ($urandom_range(1) == 0) ? (s + 1) % nodes_in_use
                                                             : $urandom_range(nodes_in_use - 1));
      else if (pick < 50)
        queue_request(KIND_EDGE, $urandom_range(255), $urandom_range(255));
      else if (pick < 88)
        queue_request(KIND_QUERY, s, $urandom_range(255));
      else if (pick < 94)
        queue_request(KIND_QUERY, $urandom_range(255), $urandom_range(255));
      else if (pick < 97)
        queue_request(KIND_CLEAR, $urandom_range(255), $urandom_range(255));
      else
        queue_request(KIND_UNUSED, $urandom_range(255), $urandom_range(255));
    end
  endtask

  initial begin
    while (cycle_cnt < 200000 + 12000 * items_sent) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    req_if.valid    = 1'b0;
    req_if.kind     = KIND_EDGE;
    req_if.src_node = '0;
    req_if.dst_node = '0;
    rsp_if.ready    = 1'b0;
    req_taken       = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    mismatch_cnt    = 0;
    cycle_cnt       = 0;
    items_sent      = 0;
    nodes_in_use    = MAX_NODES;
    clear_graph();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty graph, cycle, self loop, unused kind, clear
    set_node_count(MAX_NODES);
    queue_request(KIND_QUERY, 0, 0);
    queue_request(KIND_QUERY, 255, 255);
    queue_request(KIND_EDGE, 0, 1);
    queue_request(KIND_EDGE, 1, 2);
    queue_request(KIND_EDGE, 2, 255);
    queue_request(KIND_EDGE, 255, 0);
    queue_request(KIND_QUERY, 0, 0);
    queue_request(KIND_QUERY, 2, 0);
    queue_request(KIND_EDGE, 7, 7);
    queue_request(KIND_QUERY, 7, 0);
    queue_request(KIND_UNUSED, 255, 255);
    queue_request(KIND_EDGE, 10, 3);
    queue_request(KIND_QUERY, 10, 0);
    queue_request(KIND_CLEAR, 255, 255);
    queue_request(KIND_QUERY, 0, 255);
    // Single node: out-of-range edges drop silently, bad starts flagged
    set_node_count(1);
    queue_request(KIND_EDGE, 0, 0);
    queue_request(KIND_EDGE, 0, 1);
    queue_request(KIND_EDGE, 1, 0);
    queue_request(KIND_QUERY, 0, 0);
    queue_request(KIND_QUERY, 1, 0);
    queue_request(KIND_QUERY, 255, 0);
    set_node_count(0);
    queue_request(KIND_QUERY, 1, 0);
    // Stored arcs survive a lower node count
    set_node_count(511);
    queue_request(KIND_EDGE, 3, 200);
    queue_request(KIND_EDGE, 200, 6);
    set_node_count(4);
    queue_request(KIND_QUERY, 3, 0);
    queue_request(KIND_QUERY, 5, 0);

    run_random(60, 0, 0, MAX_NODES);
    run_random(60, 63, 0, $urandom_range(64, 2));
    run_random(60, 0, 63, 32);
    run_random(60, 7, 7, $urandom_range(MAX_NODES, 1));

    // Small dense graph, every start queried, then clear it
    set_node_count(8);
    queue_request(KIND_CLEAR, 0, 0);
    for (int n = 0; n < 12; n++)
      queue_request(KIND_EDGE, $urandom_range(7), $urandom_range(7));
    for (int n = 0; n < 8; n++) queue_request(KIND_QUERY, n, 0);
    queue_request(KIND_QUERY, 200, 0);
    queue_request(KIND_CLEAR, 0, 0);
    queue_request(KIND_QUERY, 0, 0);

    wait_quiet();
    foreach (answer_q[i]) note_mismatch("missing response", answer_q[i], '0);
    if (mismatch_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
